@@ hw/rtl/message_record_deframer_macros.svh @@
// assertion macros shared by the deframer rtl
`ifndef MESSAGE_RECORD_DEFRAMER_MACROS_SVH
`define MESSAGE_RECORD_DEFRAMER_MACROS_SVH

// same-cycle implication, held off while in reset
`define MRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// next-cycle implication, held off while in reset
`define MRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

@@ hw/rtl/mrd_pkg.sv @@
// types and constants for the message record deframer
`default_nettype none

package mrd_pkg;

   localparam int SENDER_ID_BYTES_DEF = 16;
   localparam int LENGTH_BITS_DEF     = 20;

   localparam int BYTE_W    = 8;
   localparam int PLEN_W    = 20;
   localparam int KIND_W    = 2;
   localparam int SIDX_W    = 4;
   localparam int WORD_W    = 32;
   localparam int WORD_BYTES = 4;
   // id (4), type (1), size (4) after the sender id
   localparam int FIXED_HDR_BYTES = 9;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_CONTENT,
      PH_DRAIN
   } phase_type;

   localparam logic [KIND_W-1:0] KIND_SENDER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/message_record_deframer.sv @@
// message record deframer: splits a length-prefixed byte payload into records
// one request byte per cycle while req_stall is low; a result, when a byte makes one, is registered in the cycle after
// sustained rate is one byte per cycle while rsp_stall is low, set by the result register handshake
// request side stalls only while a held result is itself stalled
// synchronous reset returns the parser to idle with no result pending
`default_nettype none

`include "message_record_deframer_macros.svh"

module message_record_deframer #(
   parameter int SENDER_ID_BYTES = mrd_pkg::SENDER_ID_BYTES_DEF,
   parameter int LENGTH_BITS     = mrd_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mrd_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                          req_first_byte,
   input  wire logic [mrd_pkg::PLEN_W-1:0]    req_payload_length,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mrd_pkg::KIND_W-1:0]         rsp_result_kind,
   output logic [mrd_pkg::BYTE_W-1:0]         rsp_result_byte,
   output logic [mrd_pkg::SIDX_W-1:0]         rsp_sender_index,
   output logic [mrd_pkg::WORD_W-1:0]         rsp_message_id,
   output logic [mrd_pkg::BYTE_W-1:0]         rsp_message_type,
   output logic [mrd_pkg::WORD_W-1:0]         rsp_content_length,
   output logic                               rsp_content_dropped,
   output logic                               rsp_end_of_message
);
   import mrd_pkg::*;

   // full header size and the widths that follow from it
   localparam int HDR_BYTES = SENDER_ID_BYTES + FIXED_HDR_BYTES;
   localparam int CNT_W     = $clog2(HDR_BYTES);
   // the length port is fixed width, so a wider mask keeps every bit
   localparam int REM_W     = (LENGTH_BITS < PLEN_W) ? LENGTH_BITS : PLEN_W;

   localparam logic [CNT_W-1:0] CNT_ID_START   = CNT_W'(SENDER_ID_BYTES);
   localparam logic [CNT_W-1:0] CNT_TYPE       = CNT_W'(SENDER_ID_BYTES + WORD_BYTES);
   localparam logic [CNT_W-1:0] CNT_SIZE_START = CNT_W'(SENDER_ID_BYTES + WORD_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST       = CNT_W'(HDR_BYTES - 1);
   localparam logic [REM_W-1:0] REM_HDR        = REM_W'(HDR_BYTES);

   // parser state
   phase_type          phase_ff, phase_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0]  id_ff, id_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [WORD_W-1:0]  size_ff, size_in;
   logic [WORD_W-1:0]  cd_ff, cd_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [SIDX_W-1:0]  sidx_ff, sidx_in;
   logic [WORD_W-1:0]  mid_ff, mid_in;
   logic [BYTE_W-1:0]  mtype_ff, mtype_in;
   logic [WORD_W-1:0]  clen_ff, clen_in;
   logic               drop_ff, drop_in;
   logic               eom_ff, eom_in;

   logic               req_acc;
   logic               produce;

   // state as seen by this byte: a first byte restarts the parse
   phase_type          phase_eff;
   logic [REM_W-1:0]   rem_eff;
   logic [CNT_W-1:0]   cnt_eff;
   logic [WORD_W-1:0]  id_eff;
   logic [BYTE_W-1:0]  type_eff;
   logic [WORD_W-1:0]  size_eff;
   logic [WORD_W-1:0]  cd_eff;

   logic               active;
   logic [REM_W-1:0]   rem_m1;
   logic               in_hdr;
   logic               hdr_short;
   logic               hdr_go;
   logic               in_sender;
   logic               in_id;
   logic               is_type;
   logic               in_size;
   logic               hdr_last;
   logic [CNT_W-1:0]   id_off;
   logic [CNT_W-1:0]   size_off;
   logic [WORD_W-1:0]  id_rep;
   logic [WORD_W-1:0]  size_rep;
   logic               fits;
   logic               has_content;
   logic               in_content;
   logic [WORD_W-1:0]  cd_dec;
   logic               content_done;

   // the result register frees up when empty or when its result is taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_acc   = req_valid & ~req_stall;

   assign phase_eff = req_first_byte ? PH_HEADER : phase_ff;
   assign rem_eff   = req_first_byte ? req_payload_length[REM_W-1:0] : rem_ff;
   assign cnt_eff   = req_first_byte ? '0 : cnt_ff;
   assign id_eff    = req_first_byte ? '0 : id_ff;
   assign type_eff  = req_first_byte ? '0 : type_ff;
   assign size_eff  = req_first_byte ? '0 : size_ff;
   assign cd_eff    = req_first_byte ? '0 : cd_ff;

   // a byte counts only inside a payload with bytes left
   assign active = (phase_eff != PH_IDLE) && (rem_eff != '0);
   assign rem_m1 = rem_eff - REM_W'(1);

   // header field decode from the byte position in the record
   assign in_hdr    = active && (phase_eff == PH_HEADER);
   // too few bytes left for a whole record: drain the tail silently
   assign hdr_short = in_hdr && (cnt_eff == '0) && (rem_eff < REM_HDR);
   assign hdr_go    = in_hdr && !hdr_short;
   assign in_sender = cnt_eff < CNT_ID_START;
   assign in_id     = !in_sender && (cnt_eff < CNT_TYPE);
   assign is_type   = cnt_eff == CNT_TYPE;
   assign in_size   = cnt_eff >= CNT_SIZE_START;
   assign hdr_last  = hdr_go && (cnt_eff == CNT_LAST);

   assign id_off   = cnt_eff - CNT_ID_START;
   assign size_off = cnt_eff - CNT_SIZE_START;

   // little-endian byte insert into id and size words
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         id_rep[BYTE_W*i +: BYTE_W]   = (id_off[1:0] == 2'(i)) ? req_data_byte
                                        : id_eff[BYTE_W*i +: BYTE_W];
         size_rep[BYTE_W*i +: BYTE_W] = (size_off[1:0] == 2'(i)) ? req_data_byte
                                        : size_eff[BYTE_W*i +: BYTE_W];
      end
   end

   // content must fit in what follows the last header byte
   assign fits        = size_rep <= {{(WORD_W-REM_W){1'b0}}, rem_m1};
   assign has_content = fits && (size_rep != '0);

   assign in_content   = active && (phase_eff == PH_CONTENT);
   assign cd_dec       = (cd_eff != '0) ? (cd_eff - WORD_W'(1)) : cd_eff;
   assign content_done = cd_dec == '0;

   // next parse phase
   always_comb begin
      phase_in = phase_eff;
      if (!active) begin
         phase_in = PH_IDLE;
      end else begin
         unique case (phase_eff)
            PH_HEADER: begin
               if (hdr_short) begin
                  phase_in = PH_DRAIN;
               end else if (hdr_last && has_content) begin
                  phase_in = PH_CONTENT;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
            PH_CONTENT: begin
               phase_in = content_done ? PH_HEADER : PH_CONTENT;
            end
            PH_DRAIN: begin
               phase_in = PH_DRAIN;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         // payload used up
         if (rem_m1 == '0) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // datapath and result fields
   always_comb begin
      rem_in  = active ? rem_m1 : rem_eff;
      cnt_in  = cnt_eff;
      id_in   = id_eff;
      type_in = type_eff;
      size_in = size_eff;
      cd_in   = cd_eff;

      if (hdr_go) begin
         cnt_in = hdr_last ? '0 : (cnt_eff + CNT_W'(1));
         if (cnt_eff == '0) begin
            id_in   = '0;
            type_in = '0;
            size_in = '0;
         end else if (in_id) begin
            id_in = id_rep;
         end else if (is_type) begin
            type_in = req_data_byte;
         end else if (in_size) begin
            size_in = size_rep;
         end
         if (hdr_last && has_content) begin
            cd_in = size_rep;
         end
      end else if (in_content) begin
         cd_in = cd_dec;
         if (content_done) begin
            cnt_in = '0;
         end
      end

      produce  = 1'b0;
      kind_in  = KIND_SENDER;
      byte_in  = '0;
      sidx_in  = '0;
      mid_in   = '0;
      mtype_in = '0;
      clen_in  = '0;
      drop_in  = 1'b0;
      eom_in   = 1'b0;
      priority if (hdr_last) begin
         produce  = 1'b1;
         kind_in  = KIND_HEADER;
         mid_in   = id_eff;
         mtype_in = type_eff;
         clen_in  = size_rep;
         drop_in  = !fits;
         eom_in   = !has_content;
      end else if (hdr_go && in_sender) begin
         produce = 1'b1;
         kind_in = KIND_SENDER;
         byte_in = req_data_byte;
         sidx_in = cnt_eff[SIDX_W-1:0];
      end else if (in_content) begin
         produce = 1'b1;
         kind_in = KIND_CONTENT;
         byte_in = req_data_byte;
         eom_in  = content_done;
      end else begin
         produce = 1'b0;
      end
   end

   // result valid: loaded on a request, cleared once taken
   always_comb begin
      if (req_acc) begin
         rsp_valid_in = produce;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rem_ff       <= '0;
         cnt_ff       <= '0;
         cd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            phase_ff <= phase_in;
            rem_ff   <= rem_in;
            cnt_ff   <= cnt_in;
            cd_ff    <= cd_in;
         end
      end
   end

   // header assembly, cleared at each record start
   always_ff @(posedge clock) begin
      if (req_acc) begin
         id_ff   <= id_in;
         type_ff <= type_in;
         size_ff <= size_in;
      end
   end

   // result payload, only loaded when a result is produced
   always_ff @(posedge clock) begin
      if (req_acc && produce) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         sidx_ff  <= sidx_in;
         mid_ff   <= mid_in;
         mtype_ff <= mtype_in;
         clen_ff  <= clen_in;
         drop_ff  <= drop_in;
         eom_ff   <= eom_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_result_byte     = byte_ff;
   assign rsp_sender_index    = sidx_ff;
   assign rsp_message_id      = mid_ff;
   assign rsp_message_type    = mtype_ff;
   assign rsp_content_length  = clen_ff;
   assign rsp_content_dropped = drop_ff;
   assign rsp_end_of_message  = eom_ff;

   // a live parse always has payload bytes left
   `MRD_ASSERT_NOW(a_live_has_bytes, clock, reset, phase_ff != PH_IDLE, rem_ff != '0)
   // content phase never sits with nothing left to count
   `MRD_ASSERT_NOW(a_content_count, clock, reset, phase_ff == PH_CONTENT, cd_ff != '0)
   // header position stays inside the record header
   `MRD_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_LAST)

endmodule

`default_nettype wire
